// File: design/moe_pkg.sv
// ----------------------------------------------------------------------------
// moe_pkg
// Shared constants and types of the micro-op executor.
// ----------------------------------------------------------------------------
package moe_pkg;

	localparam int GPR_COUNT  = 16;
	localparam int TEMP_COUNT = 16;
	localparam int MEM_BYTES  = 65536;
	localparam int FLAG_COUNT = 6;
	localparam int GPR_AW     = (GPR_COUNT > 1) ? $clog2(GPR_COUNT) : 1;
	localparam int TEMP_AW    = (TEMP_COUNT > 1) ? $clog2(TEMP_COUNT) : 1;
	localparam int MEM_AW     = $clog2(MEM_BYTES);
	localparam int REG_AW     = 1 + ((GPR_AW > TEMP_AW) ? GPR_AW : TEMP_AW);
	localparam int REG_DEPTH  = 2 ** REG_AW;
	localparam logic [1:0] FLAG_SET_MARK = 2'd2;

	typedef enum logic [4:0] {
		K_NULL = 5'd0, K_MOV = 5'd1, K_ADD = 5'd2, K_SUB = 5'd3, K_MUL = 5'd4,
		K_DIV = 5'd5, K_REM = 5'd6, K_OR = 5'd7, K_XOR = 5'd8, K_SHL = 5'd9,
		K_SHR = 5'd10, K_LD8 = 5'd11, K_LD16 = 5'd12, K_LD32 = 5'd13,
		K_LD64 = 5'd14, K_ST8 = 5'd15, K_ST16 = 5'd16, K_ST32 = 5'd17,
		K_ST64 = 5'd18, K_FLAG = 5'd19
	} kind_t;

	typedef enum logic [2:0] {
		M_NONE = 3'd0, M_IMM = 3'd1, M_G64 = 3'd2, M_G32 = 3'd3,
		M_G16 = 3'd4, M_G8 = 3'd5, M_TEMP = 3'd6, M_FLAG = 3'd7
	} mode_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_IMM  = 2'd2;

	typedef struct packed {
		logic        start;
		logic        rem;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] value;
	} div_rsp_t;

endpackage

// File: design/micro_op_executor_unit.sv
// ----------------------------------------------------------------------------
// micro_op_executor_unit
// Executes one micro-op per request against registers, flags and byte memory.
// ----------------------------------------------------------------------------
// One request at a time. An ALU op or flag write passes through three
// register-memory reads, execute, write back and output before a valid
// result; mul runs on a 32 by 32 bit multiplier, div and rem wait for the
// bit-serial divider; loads read each byte in a memory state and capture it
// in a wait state, stores write each byte in a memory state (1 to 8 bytes).
// The next request is taken once the result has been taken. After reset a
// clearing pass zeroes the byte memory, one byte a cycle, before the first request.
module micro_op_executor_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// kind[4:0], a_mode[7:5], a_value[71:8], b_mode[74:72], b_value[138:75],
	// d_mode[141:139], d_value[205:142], zero fill
	input  logic [207:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result_value[63:0], mem_address[79:64], status[81:80], zero fill
	output logic [87:0]  m_tdata
);
	import moe_pkg::*;

	typedef enum logic [11:0] {
		S_CLR = 12'd1, S_IDLE = 12'd2, S_RA = 12'd4, S_RB = 12'd8,
		S_RD = 12'd16, S_EX = 12'd32, S_DIV = 12'd64, S_MEM = 12'd128,
		S_MWAIT = 12'd256, S_WB = 12'd512, S_OUT = 12'd1024, S_MUL = 12'd2048
	} state_t;

	state_t       state_q;
	logic [MEM_AW-1:0] clr_q;
	logic [4:0]   kind_q;
	logic [2:0]   am_q, bm_q, dm_q;
	logic [63:0]  av_q, bv_q, dv_q;
	logic [63:0]  s0_q, s1_q, sd_q, res_q;
	logic [MEM_AW-1:0] addr_q;
	logic [1:0]   status_q;
	logic [3:0]   bcnt_q;
	logic [3:0]   size_q;
	logic [1:0]   mcnt_q;
	logic         out_v_q;
	logic [81:0]  out_q;
	logic [1:0]   flags_q [FLAG_COUNT];

	logic [REG_AW-1:0] rf_raddr, rf_waddr;
	logic [63:0]  rf_rdata, rf_wdata;
	logic         rf_we;
	logic [MEM_AW-1:0] bm_raddr, bm_waddr;
	logic [7:0]   bm_rdata, bm_wdata;
	logic         bm_we;
	div_req_t     dreq;
	div_rsp_t     drsp;

	function automatic logic [REG_AW:0] reg_slot(logic [2:0] m, logic [63:0] v);
		logic [REG_AW:0] r;
		r = '0;
		if ((m == M_G64 || m == M_G32 || m == M_G16 || m == M_G8) &&
		    v < 64'(GPR_COUNT))
			r = {1'b1, 1'b0, (REG_AW-1)'(v)};
		else if (m == M_TEMP && v < 64'(TEMP_COUNT))
			r = {1'b1, 1'b1, (REG_AW-1)'(v)};
		return r;
	endfunction

	function automatic logic [63:0] shape(logic [2:0] m, logic [63:0] v,
	                                     logic [63:0] rv,
	                                     logic [1:0] fl [FLAG_COUNT]);
		logic [63:0] r;
		r = '0;
		case (m)
			M_IMM:  r = v;
			M_G64, M_TEMP: r = (reg_slot(m, v) != '0) ? rv : 64'd0;
			M_G32:  r = (reg_slot(m, v) != '0) ? {32'd0, rv[31:0]} : 64'd0;
			M_G16:  r = (reg_slot(m, v) != '0) ? {48'd0, rv[15:0]} : 64'd0;
			M_G8:   r = (reg_slot(m, v) != '0) ? {56'd0, rv[7:0]} : 64'd0;
			M_FLAG: r = (v < 64'(FLAG_COUNT)) ? {62'd0, fl[v[2:0]]} : 64'd0;
			default: r = '0;
		endcase
		return r;
	endfunction

	logic [REG_AW:0] slot_in, slot_a, slot_b, slot_d;
	assign slot_in = reg_slot(s_tdata[7:5], s_tdata[71:8]);
	assign slot_a = reg_slot(am_q, av_q);
	assign slot_b = reg_slot(bm_q, bv_q);
	assign slot_d = reg_slot(dm_q, dv_q);

	logic is_ld, is_st, is_alu;
	assign is_ld  = kind_q >= K_LD8 && kind_q <= K_LD64;
	assign is_st  = kind_q >= K_ST8 && kind_q <= K_ST64;
	assign is_alu = kind_q >= K_MOV && kind_q <= K_SHR;

	always_comb begin
		case (state_q)
			S_IDLE:  rf_raddr = slot_in[REG_AW-1:0];
			S_RA:    rf_raddr = slot_b[REG_AW-1:0];
			default: rf_raddr = slot_d[REG_AW-1:0];
		endcase
	end

	assign rf_we    = state_q == S_WB && (is_alu || is_ld) && status_q == ST_OK &&
	                  slot_d[REG_AW];
	assign rf_waddr = slot_d[REG_AW-1:0];
	always_comb begin
		case (dm_q)
			M_G32:   rf_wdata = {32'd0, res_q[31:0]};
			M_G16:   rf_wdata = {48'd0, res_q[15:0]};
			M_G8:    rf_wdata = {56'd0, res_q[7:0]};
			default: rf_wdata = res_q;
		endcase
	end

	logic [MEM_AW-1:0] byte_addr;
	assign byte_addr = addr_q + MEM_AW'(bcnt_q);
	assign bm_raddr  = byte_addr;
	assign bm_we     = state_q == S_CLR || (state_q == S_MEM && is_st);
	assign bm_waddr  = (state_q == S_CLR) ? clr_q : byte_addr;
	assign bm_wdata  = (state_q == S_CLR) ? 8'd0 : 8'(sd_q >> {bcnt_q[2:0], 3'd0});

	moe_regfile u_rf (.clk, .arst_n, .raddr(rf_raddr), .rdata(rf_rdata),
	                  .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata));
	moe_bytemem u_bm (.clk, .raddr(bm_raddr), .rdata(bm_rdata),
	                  .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata));
	moe_divider u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));

	logic [31:0] mul_x, mul_y;
	logic [63:0] mul_p;
	always_comb begin
		case (mcnt_q)
			2'd0: begin
				mul_x = s0_q[31:0];
				mul_y = s1_q[31:0];
			end
			2'd1: begin
				mul_x = s0_q[31:0];
				mul_y = s1_q[63:32];
			end
			default: begin
				mul_x = s0_q[63:32];
				mul_y = s1_q[31:0];
			end
		endcase
	end
	assign mul_p = 64'(mul_x) * 64'(mul_y);

	logic div_go;
	assign div_go = state_q == S_EX && (kind_q == K_DIV || kind_q == K_REM) &&
	                s1_q != 64'd0;
	assign dreq = '{start: div_go, rem: (kind_q == K_REM), num: s0_q, den: s1_q};

	logic [63:0] st_mask;
	always_comb begin
		case (kind_q)
			K_ST8:   st_mask = 64'hff;
			K_ST16:  st_mask = 64'hffff;
			K_ST32:  st_mask = 64'hffff_ffff;
			default: st_mask = '1;
		endcase
	end

	assign s_tready = state_q == S_IDLE && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'd0, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
			for (int i = 0; i < FLAG_COUNT; i++) flags_q[i] <= 2'd0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: if (s_tvalid && s_tready) state_q <= S_RA;
				S_RA:   state_q <= S_RB;
				S_RB:   state_q <= S_RD;
				S_RD:   state_q <= S_EX;
				S_EX: begin
					if (div_go) state_q <= S_DIV;
					else if (kind_q == K_MUL) state_q <= S_MUL;
					else if (is_ld || is_st) state_q <= S_MEM;
					else state_q <= S_WB;
					if (kind_q == K_FLAG)
						for (int i = 0; i < FLAG_COUNT; i++) flags_q[i] <= FLAG_SET_MARK;
				end
				S_MUL: if (mcnt_q == 2'd2) state_q <= S_WB;
				S_DIV: if (drsp.done) state_q <= S_WB;
				S_MEM:   state_q <= is_ld ? S_MWAIT : ((bcnt_q + 4'd1 == size_q) ? S_WB : S_MEM);
				S_MWAIT: state_q <= (bcnt_q + 4'd1 == size_q) ? S_WB : S_MEM;
				S_WB:    state_q <= S_OUT;
				S_OUT: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q <= s_tdata[4:0];
				am_q <= s_tdata[7:5];     av_q <= s_tdata[71:8];
				bm_q <= s_tdata[74:72];   bv_q <= s_tdata[138:75];
				dm_q <= s_tdata[141:139]; dv_q <= s_tdata[205:142];
			end
			S_RA: s0_q <= shape(am_q, av_q, rf_rdata, flags_q);
			S_RB: s1_q <= shape(bm_q, bv_q, rf_rdata, flags_q);
			S_RD: begin
				sd_q     <= shape(dm_q, dv_q, rf_rdata, flags_q) & st_mask;
				addr_q   <= MEM_AW'(s0_q + s1_q);
				bcnt_q   <= 4'd0;
				mcnt_q   <= 2'd0;
				status_q <= ST_OK;
				res_q    <= '0;
			end
			S_EX: begin
				case (kind_q)
					K_MOV: res_q <= s0_q;
					K_ADD: res_q <= s0_q + s1_q;
					K_SUB: res_q <= s0_q - s1_q;
					K_DIV, K_REM: if (s1_q == 64'd0) status_q <= ST_DIV0;
					K_OR:  res_q <= s0_q | s1_q;
					K_XOR: res_q <= s0_q ^ s1_q;
					K_SHL: res_q <= (s1_q >= 64'd64) ? 64'd0 : s0_q << s1_q[5:0];
					K_SHR: res_q <= (s1_q >= 64'd64) ? 64'd0 : s0_q >> s1_q[5:0];
					K_ST8, K_ST16, K_ST32, K_ST64: res_q <= sd_q;
					default: res_q <= '0;
				endcase
				case (kind_q)
					K_LD8, K_ST8:   size_q <= 4'd1;
					K_LD16, K_ST16: size_q <= 4'd2;
					K_LD32, K_ST32: size_q <= 4'd4;
					default:        size_q <= 4'd8;
				endcase
			end
			S_MUL: begin
				res_q  <= res_q + ((mcnt_q == 2'd0) ? mul_p : {mul_p[31:0], 32'd0});
				mcnt_q <= mcnt_q + 2'd1;
			end
			S_DIV: if (drsp.done) res_q <= drsp.value;
			S_MEM: if (!is_ld) bcnt_q <= bcnt_q + 4'd1;
			S_MWAIT: begin
				res_q  <= res_q | (64'(bm_rdata) << {bcnt_q[2:0], 3'd0});
				bcnt_q <= bcnt_q + 4'd1;
			end
			S_WB: if ((is_alu || is_ld) && status_q == ST_OK && dm_q == M_IMM)
				status_q <= ST_IMM;
			S_OUT: out_q <= {status_q, ((is_ld || is_st) ? 16'(addr_q) : 16'd0), res_q};
			default: ;
		endcase
	end

endmodule

// File: design/moe_divider.sv
// ----------------------------------------------------------------------------
// moe_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module moe_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  moe_pkg::div_req_t req,
	output moe_pkg::div_rsp_t rsp
);
	import moe_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic        rem_q;
	logic [63:0] quo_q;
	logic [63:0] rmd_q;
	logic [63:0] den_q;
	logic [64:0] trial;

	assign trial = {rmd_q, quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			quo_q <= req.num;
			rmd_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rmd_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rmd_q <= {rmd_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q, value: (rem_q ? rmd_q : quo_q)};

endmodule

// File: design/moe_regfile.sv
// ----------------------------------------------------------------------------
// moe_regfile
// Combined general and temporary register memory, one registered read port,
// one write port, per-entry valid bits cleared at reset.
// ----------------------------------------------------------------------------
module moe_regfile (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [moe_pkg::REG_AW-1:0] raddr,
	output logic [63:0]                rdata,
	input  logic                       we,
	input  logic [moe_pkg::REG_AW-1:0] waddr,
	input  logic [63:0]                wdata
);
	import moe_pkg::*;

	logic [63:0]          mem [REG_DEPTH];
	logic [REG_DEPTH-1:0] vld_q;
	logic [63:0]          rd_q;
	logic                 rv_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			if (we) vld_q[waddr] <= 1'b1;
			rv_q <= vld_q[raddr];
		end
	end

	assign rdata = rv_q ? rd_q : 64'd0;

endmodule

// File: design/moe_bytemem.sv
// ----------------------------------------------------------------------------
// moe_bytemem
// Byte memory with one registered read port and one write port.
// ----------------------------------------------------------------------------
module moe_bytemem (
	input  logic                       clk,
	input  logic [moe_pkg::MEM_AW-1:0] raddr,
	output logic [7:0]                 rdata,
	input  logic                       we,
	input  logic [moe_pkg::MEM_AW-1:0] waddr,
	input  logic [7:0]                 wdata
);
	import moe_pkg::*;

	logic [7:0] mem [MEM_BYTES];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
